/* design/nss_pkg.sv */
// Package for the nearest segment search block: sizes, codes, item types,
// controller states and the command and status groups between controller and datapath.
// Depends on nothing; every other file imports it.
`default_nettype none

package nss_pkg;

  localparam int PT_DEPTH  = 1024;
  localparam int SEG_DEPTH = 1024;
  localparam int PT_AW     = 10;
  localparam int SEG_AW    = 10;
  localparam int COORD_W   = 32;
  localparam int CNT_W     = 11;
  localparam int DIST_W    = 31;
  localparam int BIT_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int SEG_W     = 2 * PT_AW + 1;

  localparam logic [1:0] CMD_POINT   = 2'd0;
  localparam logic [1:0] CMD_SEGMENT = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;

  localparam logic [CFG_W-1:0] CAP_RESET = 31'h7FFF_FFFF;
  localparam logic [2:0] WPH_LAST = 3'd4;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [SEG_AW-1:0]         slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [PT_AW-1:0]          seg_start;
    logic [PT_AW-1:0]          seg_end;
    logic                      seg_valid;
  } in_item_t;

  typedef struct packed {
    logic [SEG_AW-1:0] best_segment;
    logic              found;
    logic              used_fallback;
    logic              degenerate_error;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEG_RD, ST_SEG_CHK, ST_PT_LD,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_WIDE, ST_CSQ, ST_BDSQ, ST_BDL, ST_WIN_CHK,
    ST_TT, ST_TSQ, ST_TL, ST_TRY, ST_WIN, ST_PASS_END, ST_DONE
  } st_t;

  typedef enum logic [3:0] {
    MS_NONE, MS_AXDX, MS_AYDY, MS_DXDX, MS_DYDY, MS_AXDY, MS_AYDX,
    MS_BDBD, MS_TT, MS_LL, MS_LH, MS_HL, MS_HH
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD32, ACC_ADD64
  } acc_op_t;

  typedef enum logic [2:0] {
    SV_NONE, SV_INNER, SV_L2, SV_CROSS, SV_CSQ, SV_WL
  } save_t;

  typedef struct packed {
    logic     accept;
    logic     start;
    logic     rd_seg;
    logic     rd_pt;
    logic     ld_diff;
    logic     set_err;
    logic     idx_inc;
    logic     pass2;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    save_t    save;
    logic     bit_init;
    logic     bit_dec;
    logic     try_bit;
    logic     win;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic seg_ok;
    logic degen;
    logic foot_bad;
    logic on_end;
    logic bd_zero;
    logic lt;
    logic bit_zero;
    logic hit;
    logic pass2;
    logic need_second;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/nss_ctrl.sv */
// Controller of the nearest segment search: state machine that walks the segments,
// sequences the shared multiplier and drives the item handshakes.
// Depends on nss_pkg.
`default_nettype none

module nss_ctrl import nss_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd
);

  st_t        state_r, state_nxt;
  st_t        ret_r, ret_nxt;
  logic [2:0] wph_r, wph_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      wph_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      wph_r       <= wph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    wph_nxt   = wph_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_QUERY) state_nxt = ST_SEG_RD;
      end
      ST_SEG_RD:  state_nxt = st.idx_end ? ST_PASS_END : ST_SEG_CHK;
      ST_SEG_CHK: state_nxt = st.seg_ok ? ST_PT_LD : ST_SEG_RD;
      ST_PT_LD:   state_nxt = st.degen ? ST_SEG_RD : ST_M1;
      ST_M1:      state_nxt = ST_M2;
      ST_M2:      state_nxt = ST_M3;
      ST_M3:      state_nxt = ST_M4;
      ST_M4:      state_nxt = ST_M5;
      ST_M5:      state_nxt = ST_M6;
      ST_M6:      state_nxt = ST_M7;
      ST_M7:      state_nxt = ST_M8;
      ST_M8: begin
        if (!st.pass2 && st.foot_bad) begin
          state_nxt = ST_SEG_RD;
        end else if (st.on_end) begin
          state_nxt = st.bd_zero ? ST_SEG_RD : ST_WIN;
        end else begin
          state_nxt = ST_WIDE;
          wph_nxt   = 3'd0;
          ret_nxt   = ST_CSQ;
        end
      end
      ST_WIDE: begin
        if (wph_r == WPH_LAST) state_nxt = ret_r;
        else wph_nxt = wph_r + 3'd1;
      end
      ST_CSQ:  state_nxt = ST_BDSQ;
      ST_BDSQ: state_nxt = ST_BDL;
      ST_BDL: begin
        state_nxt = ST_WIDE;
        wph_nxt   = 3'd0;
        ret_nxt   = ST_WIN_CHK;
      end
      ST_WIN_CHK: state_nxt = st.lt ? ST_TT : ST_SEG_RD;
      ST_TT:      state_nxt = ST_TSQ;
      ST_TSQ:     state_nxt = ST_TL;
      ST_TL: begin
        state_nxt = ST_WIDE;
        wph_nxt   = 3'd0;
        ret_nxt   = ST_TRY;
      end
      ST_TRY: state_nxt = st.bit_zero ? ST_WIN : ST_TT;
      ST_WIN: state_nxt = ST_SEG_RD;
      ST_PASS_END: begin
        if (!st.pass2 && !st.hit && st.need_second) state_nxt = ST_SEG_RD;
        else state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MS_NONE;
    cmd.acc_op  = ACC_HOLD;
    cmd.save    = SV_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        cmd.start  = in_valid && in_cmd == CMD_QUERY;
      end
      ST_SEG_RD:  cmd.rd_seg = !st.idx_end;
      ST_SEG_CHK: begin
        cmd.idx_inc = !st.seg_ok;
        cmd.rd_pt   = st.seg_ok;
      end
      ST_PT_LD: begin
        cmd.ld_diff = 1'b1;
        cmd.set_err = st.degen;
        cmd.idx_inc = st.degen;
      end
      ST_M1: cmd.mul_sel = MS_AXDX;
      ST_M2: begin
        cmd.mul_sel = MS_AYDY;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_M3: begin
        cmd.mul_sel = MS_DXDX;
        cmd.acc_op  = ACC_ADD;
      end
      ST_M4: begin
        cmd.mul_sel = MS_DYDY;
        cmd.acc_op  = ACC_LOAD;
        cmd.save    = SV_INNER;
      end
      ST_M5: begin
        cmd.mul_sel = MS_AXDY;
        cmd.acc_op  = ACC_ADD;
      end
      ST_M6: begin
        cmd.mul_sel = MS_AYDX;
        cmd.acc_op  = ACC_LOAD;
        cmd.save    = SV_L2;
      end
      ST_M7: cmd.acc_op = ACC_SUB;
      ST_M8: begin
        cmd.save = SV_CROSS;
        if (!st.pass2 && st.foot_bad) cmd.idx_inc = 1'b1;
        else if (st.on_end && st.bd_zero) cmd.idx_inc = 1'b1;
      end
      ST_WIDE: begin
        case (wph_r)
          3'd0: cmd.mul_sel = MS_LL;
          3'd1: begin
            cmd.mul_sel = MS_LH;
            cmd.acc_op  = ACC_LOAD;
          end
          3'd2: begin
            cmd.mul_sel = MS_HL;
            cmd.acc_op  = ACC_ADD32;
          end
          3'd3: begin
            cmd.mul_sel = MS_HH;
            cmd.acc_op  = ACC_ADD32;
          end
          default: cmd.acc_op = ACC_ADD64;
        endcase
      end
      ST_CSQ: begin
        cmd.save    = SV_CSQ;
        cmd.mul_sel = MS_BDBD;
      end
      ST_BDSQ: cmd.acc_op = ACC_LOAD;
      ST_BDL:  cmd.save = SV_WL;
      ST_WIN_CHK: begin
        cmd.idx_inc  = !st.lt;
        cmd.bit_init = st.lt;
      end
      ST_TT:  cmd.mul_sel = MS_TT;
      ST_TSQ: cmd.acc_op = ACC_LOAD;
      ST_TL:  cmd.save = SV_WL;
      ST_TRY: begin
        cmd.try_bit = 1'b1;
        cmd.bit_dec = !st.bit_zero;
      end
      ST_WIN: begin
        cmd.win     = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_PASS_END: cmd.pass2 = !st.pass2 && !st.hit && st.need_second;
      ST_DONE: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: cmd.accept = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* design/nss_dp.sv */
// Datapath of the nearest segment search: point and segment stores, configuration
// registers, the shared 33x33 multiplier with its 128-bit accumulator, and the result register.
// Depends on nss_pkg.
`default_nettype none

module nss_dp import nss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctrl_cmd_t            cmd,
  input  wire in_item_t             in_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output dp_status_t                st,
  output out_item_t                 out_item
);

  logic signed [COORD_W-1:0] px_mem [PT_DEPTH];
  logic signed [COORD_W-1:0] py_mem [PT_DEPTH];
  logic [SEG_W-1:0]          seg_mem [SEG_DEPTH];

  logic [CNT_W-1:0]  points_r, faces_r;
  logic [DIST_W-1:0] cap_r, bd_r, d_r;
  logic [SEG_AW-1:0] bslot_r;
  logic [CNT_W-1:0]  idx_r;
  logic              hit_r, err_r, pass2_r;
  logic [BIT_W-1:0]  bit_r;

  logic signed [COORD_W-1:0] qx_r, qy_r, x1_q, x2_q, y1_q, y2_q;
  logic signed [COORD_W-1:0] dx_r, dy_r, ax_r, ay_r;
  logic [SEG_W-1:0]          seg_q;
  logic                      on_end_r;
  logic [63:0]               inner_r, l2_r, wa_r, wb_r;
  logic signed [65:0]        p_r;
  logic [127:0]              acc_r, acc_nxt, csq_r, p_ext;
  out_item_t                 out_r;

  logic [CNT_W-1:0]   n_eff;
  logic               on_end_c;
  logic signed [32:0] ma, mb;
  logic [DIST_W-1:0]  t_c;
  logic [63:0]        abs_c;

  function automatic logic signed [COORD_W-1:0] sat_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (d < -33'sh0_7FFF_FFFF) return 32'sh8000_0001;
    return d[COORD_W-1:0];
  endfunction

  assign n_eff    = (faces_r > CNT_W'(SEG_DEPTH)) ? CNT_W'(SEG_DEPTH) : faces_r;
  assign on_end_c = (qx_r == x1_q && qy_r == y1_q) || (qx_r == x2_q && qy_r == y2_q);
  assign t_c      = d_r | (DIST_W'(1) << bit_r);
  assign abs_c    = acc_r[63] ? (64'd0 - acc_r[63:0]) : acc_r[63:0];
  assign p_ext    = {{62{p_r[65]}}, p_r};

  assign st.idx_end     = (idx_r >= n_eff);
  assign st.seg_ok      = seg_q[SEG_W-1];
  assign st.degen       = !on_end_c && x1_q == x2_q && y1_q == y2_q;
  assign st.foot_bad    = inner_r[63] || (inner_r > l2_r);
  assign st.on_end      = on_end_r;
  assign st.bd_zero     = (bd_r == '0);
  assign st.lt          = (csq_r < acc_r);
  assign st.bit_zero    = (bit_r == '0);
  assign st.hit         = hit_r;
  assign st.pass2       = pass2_r;
  assign st.need_second = (faces_r != points_r);
  assign out_item       = out_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.cmd == CMD_POINT) px_mem[in_item.slot] <= in_item.coord_x;
    if (cmd.rd_pt) begin
      x1_q <= px_mem[seg_q[PT_AW-1:0]];
      x2_q <= px_mem[seg_q[2*PT_AW-1:PT_AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.cmd == CMD_POINT) py_mem[in_item.slot] <= in_item.coord_y;
    if (cmd.rd_pt) begin
      y1_q <= py_mem[seg_q[PT_AW-1:0]];
      y2_q <= py_mem[seg_q[2*PT_AW-1:PT_AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.cmd == CMD_SEGMENT) begin
      seg_mem[in_item.slot] <= {in_item.seg_valid, in_item.seg_end, in_item.seg_start};
    end
    if (cmd.rd_seg) seg_q <= seg_mem[idx_r[SEG_AW-1:0]];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MS_AXDX: begin ma = {ax_r[31], ax_r}; mb = {dx_r[31], dx_r}; end
      MS_AYDY: begin ma = {ay_r[31], ay_r}; mb = {dy_r[31], dy_r}; end
      MS_DXDX: begin ma = {dx_r[31], dx_r}; mb = {dx_r[31], dx_r}; end
      MS_DYDY: begin ma = {dy_r[31], dy_r}; mb = {dy_r[31], dy_r}; end
      MS_AXDY: begin ma = {ax_r[31], ax_r}; mb = {dy_r[31], dy_r}; end
      MS_AYDX: begin ma = {ay_r[31], ay_r}; mb = {dx_r[31], dx_r}; end
      MS_BDBD: begin ma = {2'b00, bd_r}; mb = {2'b00, bd_r}; end
      MS_TT:   begin ma = {2'b00, t_c}; mb = {2'b00, t_c}; end
      MS_LL:   begin ma = {1'b0, wa_r[31:0]}; mb = {1'b0, wb_r[31:0]}; end
      MS_LH:   begin ma = {1'b0, wa_r[31:0]}; mb = {1'b0, wb_r[63:32]}; end
      MS_HL:   begin ma = {1'b0, wa_r[63:32]}; mb = {1'b0, wb_r[31:0]}; end
      MS_HH:   begin ma = {1'b0, wa_r[63:32]}; mb = {1'b0, wb_r[63:32]}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:  acc_nxt = p_ext;
      ACC_ADD:   acc_nxt = acc_r + p_ext;
      ACC_SUB:   acc_nxt = acc_r - p_ext;
      ACC_ADD32: acc_nxt = acc_r + {p_ext[95:0], 32'd0};
      ACC_ADD64: acc_nxt = acc_r + {p_ext[63:0], 64'd0};
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r   <= ma * mb;
    acc_r <= acc_nxt;
    case (cmd.save)
      SV_INNER: inner_r <= acc_r[63:0];
      SV_L2:    l2_r <= acc_r[63:0];
      SV_CROSS: begin
        wa_r <= abs_c;
        wb_r <= abs_c;
      end
      SV_CSQ:   csq_r <= acc_r;
      SV_WL: begin
        wa_r <= acc_r[63:0];
        wb_r <= l2_r;
      end
      default: csq_r <= csq_r;
    endcase
    if (cmd.start) begin
      qx_r <= in_item.coord_x;
      qy_r <= in_item.coord_y;
    end
    if (cmd.ld_diff) begin
      dx_r     <= sat_diff(x2_q, x1_q);
      dy_r     <= sat_diff(y2_q, y1_q);
      ax_r     <= sat_diff(qx_r, x1_q);
      ay_r     <= sat_diff(qy_r, y1_q);
      on_end_r <= on_end_c;
      d_r      <= '0;
    end else if (cmd.try_bit && !st.lt) begin
      d_r <= t_c;
    end
    if (cmd.out_load) begin
      out_r.best_segment     <= bslot_r;
      out_r.found            <= hit_r;
      out_r.used_fallback    <= pass2_r && hit_r;
      out_r.degenerate_error <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= '0;
      faces_r  <= '0;
      cap_r    <= CAP_RESET;
      bd_r     <= CAP_RESET;
      bslot_r  <= '0;
      idx_r    <= '0;
      hit_r    <= 1'b0;
      err_r    <= 1'b0;
      pass2_r  <= 1'b0;
      bit_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POINTS: points_r <= cfg_wdata[CNT_W-1:0];
          CFG_FACES:  faces_r <= cfg_wdata[CNT_W-1:0];
          CFG_CAP:    cap_r <= cfg_wdata;
          default:    cap_r <= cap_r;
        endcase
      end
      if (cmd.start) begin
        bd_r    <= cap_r;
        bslot_r <= '0;
        idx_r   <= '0;
        hit_r   <= 1'b0;
        err_r   <= 1'b0;
        pass2_r <= 1'b0;
      end
      if (cmd.pass2) begin
        pass2_r <= 1'b1;
        idx_r   <= '0;
      end
      if (cmd.idx_inc) idx_r <= idx_r + CNT_W'(1);
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.win) begin
        bd_r    <= d_r;
        bslot_r <= idx_r[SEG_AW-1:0];
        hit_r   <= 1'b1;
      end
      if (cmd.bit_init) bit_r <= BIT_W'(DIST_W - 1);
      else if (cmd.bit_dec) bit_r <= bit_r - BIT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* design/nearest_segment_search_core.sv */
// Top level of the nearest segment search block: joins the controller and the datapath.
// Depends on nss_pkg, nss_ctrl and nss_dp.
`default_nettype none

// Point and segment write items are accepted back to back.
// A query item walks the segment slots one at a time, in up to two passes, through a
// single shared 33x33 multiplier; per slot an invalid segment is dropped right after its
// read, a segment rejected by the foot test or as degenerate leaves before the distance
// test, and a new best distance adds a 31-step square-root search, one bit per step.
// The result then goes to the output register, which holds it while new items are taken.

module nearest_segment_search_core import nss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  nss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  nss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .st        (st),
    .out_item  (out_data)
  );

`ifndef SYNTH
  a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.found || (out_data.best_segment == '0 && !out_data.used_fallback)))
    else $error("result without a segment carries a slot or fallback flag");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_QUERY) |=> in_stall)
    else $error("block took a query but did not go busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for nearest_segment_search_core: loads points and segments,
// sweeps the registers and compares every query answer against an in-bench predictor.
// Depends on nss_pkg and the RTL of the block.
`default_nettype none

module tb;
  import nss_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  nearest_segment_search_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    bit valid;
    int first;
    int last;
  } segment_rec_t;

  longint px[PT_DEPTH];
  longint py[PT_DEPTH];
  segment_rec_t segs[SEG_DEPTH];
  int ready_points[$];
  int n_points_reg;
  int n_faces_reg;
  longint cap_reg;
  longint best_dist;
  int best_idx;
  bit degen_seen;

  out_item_t pending_answers[$];
  int errors = 0;
  int answers_checked = 0;
  int fallbacks_seen = 0;
  int degens_seen = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!idle_on) begin
      out_stall <= 1'b0;
    end else begin
      if (burst_left == 0 && $urandom_range(0, 5) == 0) burst_left = $urandom_range(1, 7);
      out_stall <= (burst_left > 0);
      if (burst_left > 0) burst_left--;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer %p", $time, out_data);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (want.used_fallback) fallbacks_seen++;
        if (want.degenerate_error) degens_seen++;
        if (out_data.best_segment !== want.best_segment) begin
          $display("%0t: best_segment expected %0d actual %0d", $time,
                   want.best_segment, out_data.best_segment);
          errors++;
        end
        if (out_data.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_data.found);
          errors++;
        end
        if (out_data.used_fallback !== want.used_fallback) begin
          $display("%0t: used_fallback expected %0d actual %0d", $time,
                   want.used_fallback, out_data.used_fallback);
          errors++;
        end
        if (out_data.degenerate_error !== want.degenerate_error) begin
          $display("%0t: degenerate_error expected %0d actual %0d", $time,
                   want.degenerate_error, out_data.degenerate_error);
          errors++;
        end
      end
    end
  end

  function automatic longint clip_diff(longint a, longint b);
    longint d;
    d = a - b;
    if (d > 64'sd2147483647) return 64'sd2147483647;
    if (d < -64'sd2147483647) return -64'sd2147483647;
    return d;
  endfunction

  // One pass over the active segment slots; updates the running best.
  function automatic bit scan_segments(bit foot_test, longint qx, longint qy);
    bit hit;
    int limit;
    longint x1, y1, x2, y2, dx, dy, ax, ay, l2, inner, cr, c, d, t;
    logic [127:0] c2, bound;
    bit on_end;
    hit = 1'b0;
    limit = (n_faces_reg > SEG_DEPTH) ? SEG_DEPTH : n_faces_reg;
    for (int i = 0; i < limit; i++) begin
      if (!segs[i].valid) continue;
      x1 = px[segs[i].first];
      y1 = py[segs[i].first];
      x2 = px[segs[i].last];
      y2 = py[segs[i].last];
      on_end = (qx == x1 && qy == y1) || (qx == x2 && qy == y2);
      if (!on_end && x1 == x2 && y1 == y2) begin
        degen_seen = 1'b1;
        continue;
      end
      dx = clip_diff(x2, x1);
      dy = clip_diff(y2, y1);
      ax = clip_diff(qx, x1);
      ay = clip_diff(qy, y1);
      l2 = dx * dx + dy * dy;
      if (foot_test) begin
        inner = ax * dx + ay * dy;
        if (inner < 0 || inner > l2) continue;
      end
      d = 0;
      if (on_end) begin
        if (best_dist == 0) continue;
      end else begin
        cr = ax * dy - ay * dx;
        c = (cr < 0) ? -cr : cr;
        c2 = 128'(c) * 128'(c);
        bound = 128'(best_dist * best_dist) * 128'(l2);
        if (!(c2 < bound)) continue;
        for (int b = 30; b >= 0; b--) begin
          t = d | (64'sd1 << b);
          if (!(c2 < 128'(t * t) * 128'(l2))) d = t;
        end
      end
      best_dist = d;
      best_idx = i;
      hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic out_item_t nearest_answer(longint qx, longint qy);
    out_item_t ans;
    bit hit, second;
    best_dist = cap_reg;
    best_idx = 0;
    degen_seen = 1'b0;
    second = 1'b0;
    hit = scan_segments(1'b1, qx, qy);
    if (!hit && n_faces_reg != n_points_reg) begin
      hit = scan_segments(1'b0, qx, qy);
      second = hit;
    end
    ans.best_segment = hit ? SEG_AW'(best_idx) : '0;
    ans.found = hit;
    ans.used_fallback = second;
    ans.degenerate_error = degen_seen;
    return ans;
  endfunction

  function automatic void apply_item(in_item_t it);
    case (it.cmd)
      CMD_POINT: begin
        px[it.slot] = longint'(it.coord_x);
        py[it.slot] = longint'(it.coord_y);
        if (!(it.slot inside {ready_points})) ready_points.push_back(int'(it.slot));
      end
      CMD_SEGMENT: begin
        segs[it.slot].valid = it.seg_valid;
        segs[it.slot].first = int'(it.seg_start);
        segs[it.slot].last = int'(it.seg_end);
      end
      CMD_QUERY: pending_answers.push_back(nearest_answer(longint'(it.coord_x),
                                                          longint'(it.coord_y)));
      default: ;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POINTS: n_points_reg = int'(value & 'h7FF);
      CFG_FACES: n_faces_reg = int'(value & 'h7FF);
      CFG_CAP: cap_reg = value & 'h7FFF_FFFF;
      default: ;
    endcase
  endtask

  function automatic in_item_t random_item();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t point_item(int slot, longint x, longint y);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_POINT;
    it.slot = SEG_AW'(slot);
    it.coord_x = COORD_W'(x);
    it.coord_y = COORD_W'(y);
    return it;
  endfunction

  function automatic in_item_t segment_item(int slot, int first, int last, bit usable);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_SEGMENT;
    it.slot = SEG_AW'(slot);
    it.seg_start = PT_AW'(first);
    it.seg_end = PT_AW'(last);
    it.seg_valid = usable;
    return it;
  endfunction

  function automatic in_item_t query_item(longint x, longint y);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_QUERY;
    it.coord_x = COORD_W'(x);
    it.coord_y = COORD_W'(y);
    return it;
  endfunction

  function automatic longint near_coord();
    return longint'($urandom_range(0, 2 << 20)) - (1 << 20);
  endfunction

  function automatic int any_ready_point();
    return ready_points[$urandom_range(0, ready_points.size() - 1)];
  endfunction

  // A query near a stored point, exactly on one, or anywhere at all.
  function automatic in_item_t random_query();
    int p;
    p = any_ready_point();
    case ($urandom_range(0, 5))
      0: return query_item(px[p], py[p]);
      1: return query_item(longint'($signed($urandom)), longint'($signed($urandom)));
      default: return query_item(px[p] + near_coord() / 8, py[p] + near_coord() / 8);
    endcase
  endfunction

  task automatic test_directed();
    in_item_t junk;
    send_item(point_item(0, 0, 0));
    send_item(point_item(1, 40960, 0));
    send_item(point_item(2, 64'sd2147483647, -64'sd2147483648));
    send_item(point_item(3, 0, 0));
    send_item(point_item(1023, -64'sd2147483648, 64'sd2147483647));
    send_item(segment_item(0, 0, 1, 1'b1));
    send_item(segment_item(1, 3, 0, 1'b1));
    send_item(segment_item(2, 1023, 2, 1'b1));
    send_item(segment_item(3, 0, 1, 1'b0));
    junk = query_item(12345, 678);
    junk.cmd = CMD_UNUSED;
    send_item(junk);
    drain();
    write_reg(CFG_FACES, 4);
    write_reg(CFG_POINTS, 5);
    send_item(query_item(0, 0));
    send_item(query_item(40960, 0));
    send_item(query_item(20480, 4096));
    send_item(query_item(81920, 4096));
    send_item(query_item(-20480, -8192));
    send_item(query_item(-64'sd2147483648, 64'sd2147483647));
    send_item(query_item(64'sd2147483647, -64'sd2147483648));
    send_item(query_item(64'sd2147483647, 64'sd2147483647));
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_CAP, 0);
    send_item(query_item(0, 0));
    send_item(query_item(20480, 4096));
    drain();
    write_reg(CFG_CAP, 4096);
    write_reg(CFG_POINTS, 4);
    send_item(query_item(20480, 2048));
    send_item(query_item(81920, 2048));
    drain();
    for (int s = 4; s < 16; s++)
      send_item(segment_item(s, any_ready_point(), any_ready_point(), s == 9));
    drain();
    write_reg(CFG_CAP, 64'sd2147483647);
    write_reg(CFG_FACES, 16);
    write_reg(CFG_POINTS, 1024);
    send_item(query_item(30000, -5000));
    drain();
    write_reg(CFG_FACES, 15);
    write_reg(CFG_POINTS, 0);
    send_item(query_item(-7777, 123456));
    drain();
    write_reg(CFG_FACES, 0);
    send_item(query_item(0, 0));
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_FACES, 3);
    write_reg(CFG_POINTS, 7);
    long_hold_req = 1'b1;
    repeat (6) send_item(random_query());
    drain();
  endtask

  task automatic random_phase(int count);
    int sel, s;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PT_DEPTH - 1) : $urandom_range(0, 31);
        if ($urandom_range(0, 7) == 0)
          send_item(point_item(s, longint'($signed($urandom)), longint'($signed($urandom))));
        else
          send_item(point_item(s, near_coord(), near_coord()));
      end else if (sel < 32) begin
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SEG_DEPTH - 1)
                                         : $urandom_range(0, 11);
        if ($urandom_range(0, 9) == 0) begin
          s = any_ready_point();
          send_item(segment_item(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                              : $urandom_range(0, 11),
                                 s, s, 1'b1));
        end else begin
          send_item(segment_item(s, any_ready_point(), any_ready_point(),
                                 $urandom_range(0, 4) != 0));
        end
      end else if (sel < 96) begin
        send_item(random_query());
      end else begin
        send_item(point_item(0, 0, 0) ^ '0);
      end
    end
  endtask

  task automatic test_random();
    for (int r = 0; r < 6; r++) begin
      write_reg(CFG_FACES, $urandom_range(1, 12));
      write_reg(CFG_POINTS, ($urandom_range(0, 2) == 0) ? n_faces_reg : $urandom_range(0, 1024));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_CAP, $urandom_range(0, 1 << 16));
        1: write_reg(CFG_CAP, $urandom);
        default: write_reg(CFG_CAP, 64'sd2147483647);
      endcase
      random_phase(35);
      drain();
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_reg(CFG_FACES, 8);
    write_reg(CFG_POINTS, 9);
    write_reg(CFG_CAP, 64'sd2147483647);
    random_phase(40);
    drain();
  endtask

  initial begin
    for (int i = 0; i < SEG_DEPTH; i++) segs[i] = '{1'b0, 0, 0};
    n_points_reg = 0;
    n_faces_reg = 0;
    cap_reg = 64'sd2147483647;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();
    test_steady_stream();
    $display("Checked %0d query answers over point, segment, query and unused commands,",
             answers_checked);
    $display("with %0d second-pass picks and %0d zero-length segment flags.",
             fallbacks_seen, degens_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
design/nss_pkg.sv
design/nss_ctrl.sv
design/nss_dp.sv
design/nearest_segment_search_core.sv
tb/sv/tb.sv
